FILE: hdl/lkc_pkg.sv
package lkc_pkg;

    localparam int KEY_W     = 32;
    localparam int CAP_W     = 5;
    localparam int DEPTH_DEF = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic en;    // an item is processed this cycle
        logic hit;   // search key matched a live entry
        logic ins;   // nonzero capacity: a miss inserts at the MRU end
    } cell_ctrl_t;

endpackage

FILE: hdl/lkc_cell.sv
module lkc_cell
(
    input  logic                         clk,
    input  lkc_pkg::cell_ctrl_t          ctrl,
    input  logic [lkc_pkg::KEY_W-1:0]    search_key,
    input  logic                         live,
    input  logic [lkc_pkg::KEY_W-1:0]    prev_key,
    input  logic                         match_beyond_in,
    output logic [lkc_pkg::KEY_W-1:0]    stored_key,
    output logic                         match_beyond_out
);

    logic [lkc_pkg::KEY_W-1:0] key_reg;
    logic                      match_here;
    logic                      take;

    assign match_here       = live && (key_reg == search_key);
    assign match_beyond_out = match_here || match_beyond_in;

    // On a hit, every entry up to and including the matching one moves one
    // step toward the old end; on an insert the whole row moves.
    assign take = ctrl.en && (ctrl.hit ? match_beyond_out : ctrl.ins);

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            key_reg <= prev_key;
        end
    end

    assign stored_key = key_reg;

endmodule

FILE: hdl/lru_key_cache.sv
// lru_key_cache: fully associative key cache kept in recency order.
//
// Lookup channel (lookup_valid/lookup_ready, lookup_key): one beat per key.
// Result channel (hit_valid/hit_ready, hit): one beat per lookup, in order;
//   hit is 1 when the key was held, 0 on a miss (the key is then inserted).
// Capacity channel (capacity_valid/capacity_ready, capacity): always ready;
//   write only while no lookup is outstanding. Values above DEPTH act as
//   DEPTH; zero means misses store nothing.
//
// Entries sit in a row of DEPTH cells, most recently used in cell 0. Every
// cell compares its key against the search key in parallel, and the row
// shifts one step in the same cycle, so the block takes one key per cycle
// while hit_ready keeps the result slot free. A key is registered on accept,
// then looked up and the row updated, and the result beat is registered.
// The match chain through the row sets the critical path.
//
// Reset empties the cache (fill count zero) and sets capacity to 16; cell
// contents are not cleared. A result beat waiting with hit_ready low holds;
// a full one-key input register holds; lookup_ready drops until a beat leaves.
module lru_key_cache
#(
    parameter int DEPTH = lkc_pkg::DEPTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             lookup_valid,
    output logic                             lookup_ready,
    input  logic signed [lkc_pkg::KEY_W-1:0] lookup_key,
    output logic                             hit_valid,
    input  logic                             hit_ready,
    output logic                             hit,
    input  logic                             capacity_valid,
    output logic                             capacity_ready,
    input  logic [lkc_pkg::CAP_W-1:0]        capacity
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > lkc_pkg::CAP_W) ? CW : lkc_pkg::CAP_W;

    logic [lkc_pkg::CAP_W-1:0] cap_reg;
    logic [CW-1:0]             fill_reg;
    logic [CW-1:0]             fill_next;
    logic                      key_valid_reg;
    logic [lkc_pkg::KEY_W-1:0] key_reg;
    logic                      out_valid_reg;
    logic                      hit_reg;

    logic                      fire;
    logic                      any_hit;
    logic [CMPW-1:0]           cap_ext;
    logic [CW-1:0]             eff_cap;
    logic [CW-1:0]             cap_m1;
    logic [CW-1:0]             keep;
    lkc_pkg::cell_ctrl_t       ctrl;

    logic [lkc_pkg::KEY_W-1:0] cell_key [DEPTH];
    logic [DEPTH:0]            match_chain;

    // Process the held key when the result slot is free or draining.
    assign fire         = key_valid_reg && (!out_valid_reg || hit_ready);
    assign lookup_ready = !key_valid_reg || fire;
    assign capacity_ready = 1'b1;

    assign hit_valid = out_valid_reg;
    assign hit       = hit_reg;

    // Capacity clamped to the built depth
    assign cap_ext = CMPW'(cap_reg);
    assign eff_cap = (cap_ext > CMPW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_ext);
    assign cap_m1  = eff_cap - 1'b1;
    // On insert keep only the newest capacity-1 entries, then append
    assign keep    = (fill_reg > cap_m1) ? cap_m1 : fill_reg;

    assign any_hit  = match_chain[0];
    assign ctrl.en  = fire;
    assign ctrl.hit = any_hit;
    assign ctrl.ins = (eff_cap != '0);

    always_comb
    begin
        fill_next = fill_reg;
        if (fire && !any_hit && ctrl.ins)
        begin
            fill_next = keep + 1'b1;
        end
    end

    assign match_chain[DEPTH] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [lkc_pkg::KEY_W-1:0] prev_key;
        logic                      live;

        if (g == 0)
        begin : g_head
            assign prev_key = key_reg;
        end
        else
        begin : g_body
            assign prev_key = cell_key[g-1];
        end

        assign live = (CW'(g) < fill_reg);

        lkc_cell u_cell
        (
            .clk              (clk),
            .ctrl             (ctrl),
            .search_key       (key_reg),
            .live             (live),
            .prev_key         (prev_key),
            .match_beyond_in  (match_chain[g+1]),
            .stored_key       (cell_key[g]),
            .match_beyond_out (match_chain[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= lkc_pkg::CAP_RESET;
            fill_reg      <= '0;
            key_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (capacity_valid)
            begin
                cap_reg <= capacity;
            end
            fill_reg <= fill_next;
            if (lookup_ready)
            begin
                key_valid_reg <= lookup_valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (hit_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (lookup_valid && lookup_ready)
        begin
            key_reg <= lookup_key;
        end
        if (fire)
        begin
            hit_reg <= any_hit;
        end
    end

endmodule
